>>> rtl/core/flrg_pkg.sv
// shared types, constants and the db-to-linear gain table for the floor line renderer
`timescale 1ns / 1ps

package flrg_pkg;

   // field widths
   localparam int SAMPLE_BITS  = 24;
   localparam int GAIN_ENTRIES = 256;
   localparam int POS_BITS     = 16;
   localparam int IDX_BITS     = 8;
   localparam int LEVEL_BITS   = 9;
   localparam int GAIN_BITS    = 32;

   // stream packing, zero padded to whole bytes
   localparam int REQ_FIELD_BITS = 2 * POS_BITS + 2 * IDX_BITS + SAMPLE_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = POS_BITS + IDX_BITS + GAIN_BITS + SAMPLE_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // serial divider: one quotient bit per step
   localparam int DIV_STEPS      = IDX_BITS;
   localparam int DIV_COUNT_BITS = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_GAIN,
      ST_SCALE
   } flrg_state_type;

   typedef struct packed {
      logic                start;
      logic [IDX_BITS-1:0] dividend;
      logic [POS_BITS-1:0] divisor;
   } flrg_div_req_type;

   typedef struct packed {
      logic                done;
      logic [IDX_BITS-1:0] quotient;
      logic [POS_BITS-1:0] remainder;
   } flrg_div_rsp_type;

   localparam logic [63:0] POW7  = 64'd10000000;
   localparam logic [63:0] POW8  = 64'd100000000;
   localparam logic [63:0] POW9  = 64'd1000000000;
   localparam logic [63:0] POW10 = 64'd10000000000;
   localparam logic [63:0] POW11 = 64'd100000000000;
   localparam logic [63:0] POW12 = 64'd1000000000000;
   localparam logic [63:0] POW13 = 64'd10000000000000;
   localparam logic [63:0] POW14 = 64'd100000000000000;

   // unsigned q1.31, each entry rounded to nearest with halves up
   localparam logic [GAIN_BITS-1:0] GAIN_ROM [GAIN_ENTRIES] = '{
      32'(((64'd10649863 << 31) + POW14 / 2) / POW14),
      32'(((64'd11341951 << 31) + POW14 / 2) / POW14),
      32'(((64'd12079015 << 31) + POW14 / 2) / POW14),
      32'(((64'd12863978 << 31) + POW14 / 2) / POW14),
      32'(((64'd13699951 << 31) + POW14 / 2) / POW14),
      32'(((64'd14590251 << 31) + POW14 / 2) / POW14),
      32'(((64'd15538408 << 31) + POW14 / 2) / POW14),
      32'(((64'd16548181 << 31) + POW14 / 2) / POW14),
      32'(((64'd17623575 << 31) + POW14 / 2) / POW14),
      32'(((64'd18768855 << 31) + POW14 / 2) / POW14),
      32'(((64'd19988561 << 31) + POW14 / 2) / POW14),
      32'(((64'd2128753 << 31) + POW13 / 2) / POW13),
      32'(((64'd22670913 << 31) + POW14 / 2) / POW14),
      32'(((64'd24144197 << 31) + POW14 / 2) / POW14),
      32'(((64'd25713223 << 31) + POW14 / 2) / POW14),
      32'(((64'd27384213 << 31) + POW14 / 2) / POW14),
      32'(((64'd29163793 << 31) + POW14 / 2) / POW14),
      32'(((64'd31059021 << 31) + POW14 / 2) / POW14),
      32'(((64'd33077411 << 31) + POW14 / 2) / POW14),
      32'(((64'd35226968 << 31) + POW14 / 2) / POW14),
      32'(((64'd37516214 << 31) + POW14 / 2) / POW14),
      32'(((64'd39954229 << 31) + POW14 / 2) / POW14),
      32'(((64'd42550680 << 31) + POW14 / 2) / POW14),
      32'(((64'd45315863 << 31) + POW14 / 2) / POW14),
      32'(((64'd48260743 << 31) + POW14 / 2) / POW14),
      32'(((64'd51396998 << 31) + POW14 / 2) / POW14),
      32'(((64'd54737065 << 31) + POW14 / 2) / POW14),
      32'(((64'd58294187 << 31) + POW14 / 2) / POW14),
      32'(((64'd62082472 << 31) + POW14 / 2) / POW14),
      32'(((64'd66116941 << 31) + POW14 / 2) / POW14),
      32'(((64'd70413592 << 31) + POW14 / 2) / POW14),
      32'(((64'd74989464 << 31) + POW14 / 2) / POW14),
      32'(((64'd79862701 << 31) + POW14 / 2) / POW14),
      32'(((64'd85052630 << 31) + POW14 / 2) / POW14),
      32'(((64'd90579828 << 31) + POW14 / 2) / POW14),
      32'(((64'd96466216 << 31) + POW14 / 2) / POW14),
      32'(((64'd10273513 << 31) + POW13 / 2) / POW13),
      32'(((64'd10941144 << 31) + POW13 / 2) / POW13),
      32'(((64'd11652161 << 31) + POW13 / 2) / POW13),
      32'(((64'd12409384 << 31) + POW13 / 2) / POW13),
      32'(((64'd13215816 << 31) + POW13 / 2) / POW13),
      32'(((64'd14074654 << 31) + POW13 / 2) / POW13),
      32'(((64'd14989305 << 31) + POW13 / 2) / POW13),
      32'(((64'd15963394 << 31) + POW13 / 2) / POW13),
      32'(((64'd17000785 << 31) + POW13 / 2) / POW13),
      32'(((64'd18105592 << 31) + POW13 / 2) / POW13),
      32'(((64'd19282195 << 31) + POW13 / 2) / POW13),
      32'(((64'd20535261 << 31) + POW13 / 2) / POW13),
      32'(((64'd21869758 << 31) + POW13 / 2) / POW13),
      32'(((64'd23290978 << 31) + POW13 / 2) / POW13),
      32'(((64'd24804557 << 31) + POW13 / 2) / POW13),
      32'(((64'd26416497 << 31) + POW13 / 2) / POW13),
      32'(((64'd28133190 << 31) + POW13 / 2) / POW13),
      32'(((64'd29961443 << 31) + POW13 / 2) / POW13),
      32'(((64'd31908506 << 31) + POW13 / 2) / POW13),
      32'(((64'd33982101 << 31) + POW13 / 2) / POW13),
      32'(((64'd36190449 << 31) + POW13 / 2) / POW13),
      32'(((64'd38542308 << 31) + POW13 / 2) / POW13),
      32'(((64'd41047004 << 31) + POW13 / 2) / POW13),
      32'(((64'd43714470 << 31) + POW13 / 2) / POW13),
      32'(((64'd46555282 << 31) + POW13 / 2) / POW13),
      32'(((64'd49580707 << 31) + POW13 / 2) / POW13),
      32'(((64'd52802740 << 31) + POW13 / 2) / POW13),
      32'(((64'd56234160 << 31) + POW13 / 2) / POW13),
      32'(((64'd59888572 << 31) + POW13 / 2) / POW13),
      32'(((64'd63780469 << 31) + POW13 / 2) / POW13),
      32'(((64'd67925283 << 31) + POW13 / 2) / POW13),
      32'(((64'd72339451 << 31) + POW13 / 2) / POW13),
      32'(((64'd77040476 << 31) + POW13 / 2) / POW13),
      32'(((64'd82047000 << 31) + POW13 / 2) / POW13),
      32'(((64'd87378876 << 31) + POW13 / 2) / POW13),
      32'(((64'd93057248 << 31) + POW13 / 2) / POW13),
      32'(((64'd99104632 << 31) + POW13 / 2) / POW13),
      32'(((64'd10554501 << 31) + POW12 / 2) / POW12),
      32'(((64'd11240392 << 31) + POW12 / 2) / POW12),
      32'(((64'd11970856 << 31) + POW12 / 2) / POW12),
      32'(((64'd12748789 << 31) + POW12 / 2) / POW12),
      32'(((64'd13577278 << 31) + POW12 / 2) / POW12),
      32'(((64'd14459606 << 31) + POW12 / 2) / POW12),
      32'(((64'd15399272 << 31) + POW12 / 2) / POW12),
      32'(((64'd16400004 << 31) + POW12 / 2) / POW12),
      32'(((64'd17465768 << 31) + POW12 / 2) / POW12),
      32'(((64'd18600792 << 31) + POW12 / 2) / POW12),
      32'(((64'd19809576 << 31) + POW12 / 2) / POW12),
      32'(((64'd21096914 << 31) + POW12 / 2) / POW12),
      32'(((64'd22467911 << 31) + POW12 / 2) / POW12),
      32'(((64'd23928002 << 31) + POW12 / 2) / POW12),
      32'(((64'd25482978 << 31) + POW12 / 2) / POW12),
      32'(((64'd27139006 << 31) + POW12 / 2) / POW12),
      32'(((64'd28902651 << 31) + POW12 / 2) / POW12),
      32'(((64'd30780908 << 31) + POW12 / 2) / POW12),
      32'(((64'd32781225 << 31) + POW12 / 2) / POW12),
      32'(((64'd34911534 << 31) + POW12 / 2) / POW12),
      32'(((64'd37180282 << 31) + POW12 / 2) / POW12),
      32'(((64'd39596466 << 31) + POW12 / 2) / POW12),
      32'(((64'd42169667 << 31) + POW12 / 2) / POW12),
      32'(((64'd44910090 << 31) + POW12 / 2) / POW12),
      32'(((64'd47828601 << 31) + POW12 / 2) / POW12),
      32'(((64'd50936773 << 31) + POW12 / 2) / POW12),
      32'(((64'd54246931 << 31) + POW12 / 2) / POW12),
      32'(((64'd57772202 << 31) + POW12 / 2) / POW12),
      32'(((64'd61526565 << 31) + POW12 / 2) / POW12),
      32'(((64'd65524908 << 31) + POW12 / 2) / POW12),
      32'(((64'd69783085 << 31) + POW12 / 2) / POW12),
      32'(((64'd74317983 << 31) + POW12 / 2) / POW12),
      32'(((64'd79147585 << 31) + POW12 / 2) / POW12),
      32'(((64'd84291040 << 31) + POW12 / 2) / POW12),
      32'(((64'd89768747 << 31) + POW12 / 2) / POW12),
      32'(((64'd95602426 << 31) + POW12 / 2) / POW12),
      32'(((64'd10181521 << 31) + POW11 / 2) / POW11),
      32'(((64'd10843174 << 31) + POW11 / 2) / POW11),
      32'(((64'd11547824 << 31) + POW11 / 2) / POW11),
      32'(((64'd12298267 << 31) + POW11 / 2) / POW11),
      32'(((64'd13097477 << 31) + POW11 / 2) / POW11),
      32'(((64'd13948625 << 31) + POW11 / 2) / POW11),
      32'(((64'd14855085 << 31) + POW11 / 2) / POW11),
      32'(((64'd15820453 << 31) + POW11 / 2) / POW11),
      32'(((64'd16848555 << 31) + POW11 / 2) / POW11),
      32'(((64'd17943469 << 31) + POW11 / 2) / POW11),
      32'(((64'd19109536 << 31) + POW11 / 2) / POW11),
      32'(((64'd20351382 << 31) + POW11 / 2) / POW11),
      32'(((64'd21673929 << 31) + POW11 / 2) / POW11),
      32'(((64'd23082423 << 31) + POW11 / 2) / POW11),
      32'(((64'd24582449 << 31) + POW11 / 2) / POW11),
      32'(((64'd26179955 << 31) + POW11 / 2) / POW11),
      32'(((64'd27881276 << 31) + POW11 / 2) / POW11),
      32'(((64'd29693158 << 31) + POW11 / 2) / POW11),
      32'(((64'd31622787 << 31) + POW11 / 2) / POW11),
      32'(((64'd33677814 << 31) + POW11 / 2) / POW11),
      32'(((64'd35866388 << 31) + POW11 / 2) / POW11),
      32'(((64'd38197188 << 31) + POW11 / 2) / POW11),
      32'(((64'd40679456 << 31) + POW11 / 2) / POW11),
      32'(((64'd43323036 << 31) + POW11 / 2) / POW11),
      32'(((64'd46138411 << 31) + POW11 / 2) / POW11),
      32'(((64'd49136745 << 31) + POW11 / 2) / POW11),
      32'(((64'd52329927 << 31) + POW11 / 2) / POW11),
      32'(((64'd55730621 << 31) + POW11 / 2) / POW11),
      32'(((64'd59352311 << 31) + POW11 / 2) / POW11),
      32'(((64'd63209358 << 31) + POW11 / 2) / POW11),
      32'(((64'd67317058 << 31) + POW11 / 2) / POW11),
      32'(((64'd71691700 << 31) + POW11 / 2) / POW11),
      32'(((64'd76350630 << 31) + POW11 / 2) / POW11),
      32'(((64'd81312324 << 31) + POW11 / 2) / POW11),
      32'(((64'd86596457 << 31) + POW11 / 2) / POW11),
      32'(((64'd92223983 << 31) + POW11 / 2) / POW11),
      32'(((64'd98217216 << 31) + POW11 / 2) / POW11),
      32'(((64'd10459992 << 31) + POW10 / 2) / POW10),
      32'(((64'd11139742 << 31) + POW10 / 2) / POW10),
      32'(((64'd11863665 << 31) + POW10 / 2) / POW10),
      32'(((64'd12634633 << 31) + POW10 / 2) / POW10),
      32'(((64'd13455702 << 31) + POW10 / 2) / POW10),
      32'(((64'd14330129 << 31) + POW10 / 2) / POW10),
      32'(((64'd15261382 << 31) + POW10 / 2) / POW10),
      32'(((64'd16253153 << 31) + POW10 / 2) / POW10),
      32'(((64'd17309374 << 31) + POW10 / 2) / POW10),
      32'(((64'd18434235 << 31) + POW10 / 2) / POW10),
      32'(((64'd19632195 << 31) + POW10 / 2) / POW10),
      32'(((64'd20908006 << 31) + POW10 / 2) / POW10),
      32'(((64'd22266726 << 31) + POW10 / 2) / POW10),
      32'(((64'd23713743 << 31) + POW10 / 2) / POW10),
      32'(((64'd25254795 << 31) + POW10 / 2) / POW10),
      32'(((64'd26895994 << 31) + POW10 / 2) / POW10),
      32'(((64'd28643847 << 31) + POW10 / 2) / POW10),
      32'(((64'd30505286 << 31) + POW10 / 2) / POW10),
      32'(((64'd32487691 << 31) + POW10 / 2) / POW10),
      32'(((64'd34598925 << 31) + POW10 / 2) / POW10),
      32'(((64'd36847358 << 31) + POW10 / 2) / POW10),
      32'(((64'd39241906 << 31) + POW10 / 2) / POW10),
      32'(((64'd41792066 << 31) + POW10 / 2) / POW10),
      32'(((64'd44507950 << 31) + POW10 / 2) / POW10),
      32'(((64'd47400328 << 31) + POW10 / 2) / POW10),
      32'(((64'd50480668 << 31) + POW10 / 2) / POW10),
      32'(((64'd53761186 << 31) + POW10 / 2) / POW10),
      32'(((64'd57254891 << 31) + POW10 / 2) / POW10),
      32'(((64'd60975636 << 31) + POW10 / 2) / POW10),
      32'(((64'd64938176 << 31) + POW10 / 2) / POW10),
      32'(((64'd69158225 << 31) + POW10 / 2) / POW10),
      32'(((64'd73652516 << 31) + POW10 / 2) / POW10),
      32'(((64'd78438871 << 31) + POW10 / 2) / POW10),
      32'(((64'd83536271 << 31) + POW10 / 2) / POW10),
      32'(((64'd88964928 << 31) + POW10 / 2) / POW10),
      32'(((64'd9474637 << 31) + POW9 / 2) / POW9),
      32'(((64'd10090352 << 31) + POW9 / 2) / POW9),
      32'(((64'd10746080 << 31) + POW9 / 2) / POW9),
      32'(((64'd11444421 << 31) + POW9 / 2) / POW9),
      32'(((64'd12188144 << 31) + POW9 / 2) / POW9),
      32'(((64'd12980198 << 31) + POW9 / 2) / POW9),
      32'(((64'd13823725 << 31) + POW9 / 2) / POW9),
      32'(((64'd14722068 << 31) + POW9 / 2) / POW9),
      32'(((64'd15678791 << 31) + POW9 / 2) / POW9),
      32'(((64'd16697687 << 31) + POW9 / 2) / POW9),
      32'(((64'd17782797 << 31) + POW9 / 2) / POW9),
      32'(((64'd18938423 << 31) + POW9 / 2) / POW9),
      32'(((64'd20169149 << 31) + POW9 / 2) / POW9),
      32'(((64'd21479854 << 31) + POW9 / 2) / POW9),
      32'(((64'd22875735 << 31) + POW9 / 2) / POW9),
      32'(((64'd24362330 << 31) + POW9 / 2) / POW9),
      32'(((64'd25945531 << 31) + POW9 / 2) / POW9),
      32'(((64'd27631618 << 31) + POW9 / 2) / POW9),
      32'(((64'd29427276 << 31) + POW9 / 2) / POW9),
      32'(((64'd31339626 << 31) + POW9 / 2) / POW9),
      32'(((64'd33376252 << 31) + POW9 / 2) / POW9),
      32'(((64'd35545228 << 31) + POW9 / 2) / POW9),
      32'(((64'd37855157 << 31) + POW9 / 2) / POW9),
      32'(((64'd40315199 << 31) + POW9 / 2) / POW9),
      32'(((64'd42935108 << 31) + POW9 / 2) / POW9),
      32'(((64'd45725273 << 31) + POW9 / 2) / POW9),
      32'(((64'd48696758 << 31) + POW9 / 2) / POW9),
      32'(((64'd51861348 << 31) + POW9 / 2) / POW9),
      32'(((64'd55231591 << 31) + POW9 / 2) / POW9),
      32'(((64'd58820850 << 31) + POW9 / 2) / POW9),
      32'(((64'd62643361 << 31) + POW9 / 2) / POW9),
      32'(((64'd66714279 << 31) + POW9 / 2) / POW9),
      32'(((64'd71049749 << 31) + POW9 / 2) / POW9),
      32'(((64'd75666962 << 31) + POW9 / 2) / POW9),
      32'(((64'd80584227 << 31) + POW9 / 2) / POW9),
      32'(((64'd85821044 << 31) + POW9 / 2) / POW9),
      32'(((64'd91398179 << 31) + POW9 / 2) / POW9),
      32'(((64'd97337747 << 31) + POW9 / 2) / POW9),
      32'(((64'd10366330 << 31) + POW8 / 2) / POW8),
      32'(((64'd11039993 << 31) + POW8 / 2) / POW8),
      32'(((64'd11757434 << 31) + POW8 / 2) / POW8),
      32'(((64'd12521498 << 31) + POW8 / 2) / POW8),
      32'(((64'd13335215 << 31) + POW8 / 2) / POW8),
      32'(((64'd14201813 << 31) + POW8 / 2) / POW8),
      32'(((64'd15124727 << 31) + POW8 / 2) / POW8),
      32'(((64'd16107617 << 31) + POW8 / 2) / POW8),
      32'(((64'd17154380 << 31) + POW8 / 2) / POW8),
      32'(((64'd18269168 << 31) + POW8 / 2) / POW8),
      32'(((64'd19456402 << 31) + POW8 / 2) / POW8),
      32'(((64'd20720788 << 31) + POW8 / 2) / POW8),
      32'(((64'd22067342 << 31) + POW8 / 2) / POW8),
      32'(((64'd23501402 << 31) + POW8 / 2) / POW8),
      32'(((64'd25028656 << 31) + POW8 / 2) / POW8),
      32'(((64'd26655159 << 31) + POW8 / 2) / POW8),
      32'(((64'd28387361 << 31) + POW8 / 2) / POW8),
      32'(((64'd30232132 << 31) + POW8 / 2) / POW8),
      32'(((64'd32196786 << 31) + POW8 / 2) / POW8),
      32'(((64'd34289114 << 31) + POW8 / 2) / POW8),
      32'(((64'd36517414 << 31) + POW8 / 2) / POW8),
      32'(((64'd38890521 << 31) + POW8 / 2) / POW8),
      32'(((64'd41417847 << 31) + POW8 / 2) / POW8),
      32'(((64'd44109412 << 31) + POW8 / 2) / POW8),
      32'(((64'd46975890 << 31) + POW8 / 2) / POW8),
      32'(((64'd50028648 << 31) + POW8 / 2) / POW8),
      32'(((64'd53279791 << 31) + POW8 / 2) / POW8),
      32'(((64'd56742212 << 31) + POW8 / 2) / POW8),
      32'(((64'd60429640 << 31) + POW8 / 2) / POW8),
      32'(((64'd64356699 << 31) + POW8 / 2) / POW8),
      32'(((64'd68538959 << 31) + POW8 / 2) / POW8),
      32'(((64'd72993007 << 31) + POW8 / 2) / POW8),
      32'(((64'd77736504 << 31) + POW8 / 2) / POW8),
      32'(((64'd82788260 << 31) + POW8 / 2) / POW8),
      32'(((64'd88168307 << 31) + POW8 / 2) / POW8),
      32'(((64'd9389798 << 31) + POW7 / 2) / POW7),
      32'h8000_0000
   };

endpackage

>>> rtl/core/floor_line_render_gain.sv
// floor line renderer: bresenham floor level, gain table lookup and sample scaling
`timescale 1ns / 1ps
// flow: an ordinary sample passes the gain and scale states on its way to rsp_tvalid;
//    the first sample of a valid segment first waits out the 8-step serial slope division
// one item at a time: req_tready is high only while idle, so the sequencer, the
//    one-bit-per-cycle divider and a stalled response side hold off the next request
// reset: synchronous active-high, clears sequencer, line state (not sample_ff), rsp_tvalid

module floor_line_render_gain (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // x_start[15:0], x_end[31:16], y_start[39:32], y_end[47:40], sample[71:48]
   input  logic [flrg_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // new_segment[0]
   input  logic                               req_tuser,
   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // position[15:0], floor_index[23:16], gain[55:24], scaled_sample[79:56]
   output logic [flrg_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // bad_span[0]
   output logic                               rsp_tuser
);

   localparam int XS_LSB     = 0;
   localparam int XE_LSB     = flrg_pkg::POS_BITS;
   localparam int YS_LSB     = 2 * flrg_pkg::POS_BITS;
   localparam int YE_LSB     = YS_LSB + flrg_pkg::IDX_BITS;
   localparam int SMP_LSB    = YE_LSB + flrg_pkg::IDX_BITS;
   localparam int IDX_LSB    = flrg_pkg::POS_BITS;
   localparam int GAIN_LSB   = IDX_LSB + flrg_pkg::IDX_BITS;
   localparam int SCALED_LSB = GAIN_LSB + flrg_pkg::GAIN_BITS;

   localparam int PB = flrg_pkg::POS_BITS;
   localparam int IB = flrg_pkg::IDX_BITS;
   localparam int LB = flrg_pkg::LEVEL_BITS;
   localparam int SB = flrg_pkg::SAMPLE_BITS;

   // sequencer
   flrg_pkg::flrg_state_type state_ff, state_in;

   // line state
   logic [PB-1:0] error_acc_ff, error_acc_in;
   logic [LB-1:0] level_ff, level_in;
   logic [LB-1:0] base_step_ff, base_step_in;
   logic [LB-1:0] round_step_ff, round_step_in;
   logic [PB-1:0] error_inc_ff, error_inc_in;
   logic [PB-1:0] run_length_ff, run_length_in;
   logic [PB-1:0] cur_position_ff, cur_position_in;
   logic [PB-1:0] steps_left_ff, steps_left_in;
   logic          span_bad_ff, span_bad_in;
   logic          dy_neg_ff, dy_neg_in;
   logic signed [SB-1:0] sample_ff, sample_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PB-1:0]        rsp_position_ff, rsp_position_in;
   logic [IB-1:0]        rsp_index_ff, rsp_index_in;
   logic [flrg_pkg::GAIN_BITS-1:0] rsp_gain_ff, rsp_gain_in;
   logic signed [SB-1:0] rsp_scaled_ff, rsp_scaled_in;
   logic                 rsp_bad_ff, rsp_bad_in;

   // request fields
   logic          req_new;
   logic [PB-1:0] req_x_start, req_x_end;
   logic [IB-1:0] req_y_start, req_y_end;
   logic          req_accept;

   // segment setup terms
   logic [PB:0]   run_wide;
   logic          run_ok;
   logic [LB-1:0] dy;
   logic [IB-1:0] ady;
   logic [LB-1:0] base_new;

   // bresenham step terms
   logic [PB:0]   err_sum;
   logic          err_wrap;

   // sequencer outputs
   logic gain_load;
   logic scale_fire;
   logic div_wait;

   flrg_pkg::flrg_div_req_type div_req;
   flrg_pkg::flrg_div_rsp_type div_rsp;

   logic [flrg_pkg::GAIN_BITS-1:0] unit_gain;
   logic signed [SB-1:0]           unit_scaled;

   assign req_new     = req_tuser;
   assign req_x_start = req_tdata[XS_LSB +: PB];
   assign req_x_end   = req_tdata[XE_LSB +: PB];
   assign req_y_start = req_tdata[YS_LSB +: IB];
   assign req_y_end   = req_tdata[YE_LSB +: IB];
   assign req_accept  = req_tvalid && req_tready;

   // run and rise of a new segment
   assign run_wide = {1'b0, req_x_end} - {1'b0, req_x_start};
   assign run_ok   = !run_wide[PB] && (run_wide[PB-1:0] != '0);
   assign dy       = {1'b0, req_y_end} - {1'b0, req_y_start};
   assign ady      = dy[LB-1] ? IB'(-dy) : dy[IB-1:0];

   // signed quotient from the magnitude the divider returns
   assign base_new = dy_neg_ff ? LB'(-{1'b0, div_rsp.quotient})
                               : {1'b0, div_rsp.quotient};

   // error accumulator step, wrap when it reaches the run
   assign err_sum  = {1'b0, error_acc_ff} + {1'b0, error_inc_ff};
   assign err_wrap = err_sum >= {1'b0, run_length_ff};

   // ---------------------------------------------------------------------------
   // sequencer: next state
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         flrg_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_new && run_ok) ? flrg_pkg::ST_DIVIDE : flrg_pkg::ST_GAIN;
            end
         end
         flrg_pkg::ST_DIVIDE: begin
            if (div_rsp.done) begin
               state_in = flrg_pkg::ST_GAIN;
            end
         end
         flrg_pkg::ST_GAIN: begin
            state_in = flrg_pkg::ST_SCALE;
         end
         flrg_pkg::ST_SCALE: begin
            if (scale_fire) begin
               state_in = flrg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = flrg_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // sequencer: outputs
   // ---------------------------------------------------------------------------
   always_comb begin
      req_tready = 1'b0;
      gain_load  = 1'b0;
      scale_fire = 1'b0;
      div_wait   = 1'b0;
      unique case (state_ff)
         flrg_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         flrg_pkg::ST_DIVIDE: begin
            div_wait = 1'b1;
         end
         flrg_pkg::ST_GAIN: begin
            gain_load = 1'b1;
         end
         flrg_pkg::ST_SCALE: begin
            // result register must be empty or emptying this cycle
            scale_fire = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // slope division starts with a segment that has a positive run
   assign div_req.start    = req_accept && req_new && run_ok;
   assign div_req.dividend = ady;
   assign div_req.divisor  = run_wide[PB-1:0];

   // ---------------------------------------------------------------------------
   // line state update
   // ---------------------------------------------------------------------------
   always_comb begin
      error_acc_in    = error_acc_ff;
      level_in        = level_ff;
      base_step_in    = base_step_ff;
      round_step_in   = round_step_ff;
      error_inc_in    = error_inc_ff;
      run_length_in   = run_length_ff;
      cur_position_in = cur_position_ff;
      steps_left_in   = steps_left_ff;
      span_bad_in     = span_bad_ff;
      dy_neg_in       = dy_neg_ff;
      sample_in       = sample_ff;

      if (req_accept) begin
         sample_in = req_tdata[SMP_LSB +: SB];
         if (req_new) begin
            // load endpoints, level starts at y_start
            cur_position_in = req_x_start;
            level_in        = {1'b0, req_y_start};
            error_acc_in    = '0;
            dy_neg_in       = dy[LB-1];
            if (run_ok) begin
               span_bad_in   = 1'b0;
               run_length_in = run_wide[PB-1:0];
               steps_left_in = run_wide[PB-1:0] - 1'b1;
            end else begin
               // empty or reversed span holds the start level
               span_bad_in   = 1'b1;
               base_step_in  = '0;
               round_step_in = '0;
               error_inc_in  = '0;
               run_length_in = '0;
               steps_left_in = '0;
            end
         end else begin
            cur_position_in = cur_position_ff + 1'b1;
            if (steps_left_ff != '0) begin
               if (err_wrap) begin
                  error_acc_in = PB'(err_sum - {1'b0, run_length_ff});
                  level_in     = level_ff + round_step_ff;
               end else begin
                  error_acc_in = err_sum[PB-1:0];
                  level_in     = level_ff + base_step_ff;
               end
               steps_left_in = steps_left_ff - 1'b1;
            end
         end
      end

      // slope terms land when the divider finishes
      if (div_wait && div_rsp.done) begin
         base_step_in  = base_new;
         round_step_in = dy_neg_ff ? base_new - 1'b1 : base_new + 1'b1;
         error_inc_in  = div_rsp.remainder;
      end
   end

   // ---------------------------------------------------------------------------
   // output register, holds a result while the next item is taken
   // ---------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_position_in = rsp_position_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_gain_in     = rsp_gain_ff;
      rsp_scaled_in   = rsp_scaled_ff;
      rsp_bad_in      = rsp_bad_ff;
      if (scale_fire) begin
         rsp_valid_in    = 1'b1;
         rsp_position_in = cur_position_ff;
         rsp_index_in    = level_ff[IB-1:0];
         rsp_gain_in     = unit_gain;
         rsp_scaled_in   = unit_scaled;
         rsp_bad_in      = span_bad_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= flrg_pkg::ST_IDLE;
         error_acc_ff    <= '0;
         level_ff        <= '0;
         base_step_ff    <= '0;
         round_step_ff   <= '0;
         error_inc_ff    <= '0;
         run_length_ff   <= '0;
         cur_position_ff <= '0;
         steps_left_ff   <= '0;
         span_bad_ff     <= 1'b0;
         dy_neg_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         error_acc_ff    <= error_acc_in;
         level_ff        <= level_in;
         base_step_ff    <= base_step_in;
         round_step_ff   <= round_step_in;
         error_inc_ff    <= error_inc_in;
         run_length_ff   <= run_length_in;
         cur_position_ff <= cur_position_in;
         steps_left_ff   <= steps_left_in;
         span_bad_ff     <= span_bad_in;
         dy_neg_ff       <= dy_neg_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sample_ff       <= sample_in;
      rsp_position_ff <= rsp_position_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_gain_ff     <= rsp_gain_in;
      rsp_scaled_ff   <= rsp_scaled_in;
      rsp_bad_ff      <= rsp_bad_in;
   end

   // slope divider
   flrg_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // gain lookup and multiply
   flrg_scale u_scale (
      .clock     (clock),
      .gain_load (gain_load),
      .level_idx (level_ff[IB-1:0]),
      .sample    (sample_ff),
      .gain      (unit_gain),
      .scaled    (unit_scaled)
   );

   always_comb begin
      rsp_tdata                          = '0;
      rsp_tdata[0 +: PB]                 = rsp_position_ff;
      rsp_tdata[IDX_LSB +: IB]           = rsp_index_ff;
      rsp_tdata[GAIN_LSB +: flrg_pkg::GAIN_BITS] = rsp_gain_ff;
      rsp_tdata[SCALED_LSB +: SB]        = rsp_scaled_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_bad_ff;

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------

   // a bad span never steps the level
   a_bad_span_no_steps: assert property (@(posedge clock) disable iff (reset)
      span_bad_ff |-> steps_left_ff == '0)
      else $error("bad span with steps left");

   // error accumulator stays below the run inside a valid span
   a_error_below_run: assert property (@(posedge clock) disable iff (reset)
      (!span_bad_ff && run_length_ff != '0) |-> error_acc_ff < run_length_ff)
      else $error("error accumulator reached the run");

   // the sequencer waits in the divide state until the divider reports done
   a_divide_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == flrg_pkg::ST_DIVIDE && !div_rsp.done) |=> state_ff == flrg_pkg::ST_DIVIDE)
      else $error("left divide before the quotient was ready");

   // a finished item always shows up on the response side
   a_fire_shows_result: assert property (@(posedge clock) disable iff (reset)
      scale_fire |=> rsp_valid_ff)
      else $error("scaled result lost");

   // one item at a time: an accepted transaction closes the request side
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("request taken while an item is in flight");

endmodule

>>> rtl/core/flrg_divider.sv
// serial restoring divider, one quotient bit per cycle, for the segment slope
`timescale 1ns / 1ps

module flrg_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  flrg_pkg::flrg_div_req_type div_req,
   output flrg_pkg::flrg_div_rsp_type div_rsp
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [flrg_pkg::DIV_COUNT_BITS-1:0] count_ff, count_in;
   logic [flrg_pkg::IDX_BITS-1:0]       dvd_ff, dvd_in;
   logic [flrg_pkg::POS_BITS-1:0]       dsr_ff, dsr_in;
   logic [flrg_pkg::IDX_BITS-1:0]       quo_ff, quo_in;
   logic [flrg_pkg::POS_BITS-1:0]       rem_ff, rem_in;

   logic [flrg_pkg::POS_BITS:0] trial;
   logic [flrg_pkg::POS_BITS:0] diff;
   logic                        fits;

   // partial remainder with the next dividend bit shifted in
   assign trial = {rem_ff, dvd_ff[flrg_pkg::IDX_BITS-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      dvd_in   = dvd_ff;
      dsr_in   = dsr_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         dvd_in   = div_req.dividend;
         dsr_in   = div_req.divisor;
         quo_in   = '0;
         rem_in   = '0;
      end else if (busy_ff) begin
         dvd_in   = dvd_ff << 1;
         quo_in   = {quo_ff[flrg_pkg::IDX_BITS-2:0], fits};
         rem_in   = fits ? diff[flrg_pkg::POS_BITS-1:0] : trial[flrg_pkg::POS_BITS-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == flrg_pkg::DIV_COUNT_BITS'(flrg_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

>>> rtl/core/flrg_scale.sv
// gain table lookup register and sample-by-gain multiplier
`timescale 1ns / 1ps

module flrg_scale (
   input  logic                                   clock,
   input  logic                                   gain_load,
   input  logic        [flrg_pkg::IDX_BITS-1:0]   level_idx,
   input  logic signed [flrg_pkg::SAMPLE_BITS-1:0] sample,
   output logic        [flrg_pkg::GAIN_BITS-1:0]  gain,
   output logic signed [flrg_pkg::SAMPLE_BITS-1:0] scaled
);

   localparam int PROD_BITS = flrg_pkg::SAMPLE_BITS + flrg_pkg::GAIN_BITS + 1;

   logic [flrg_pkg::GAIN_BITS-1:0] gain_ff, gain_in;
   logic signed [PROD_BITS-1:0]    product;

   always_comb begin
      gain_in = gain_ff;
      if (gain_load) begin
         gain_in = flrg_pkg::GAIN_ROM[level_idx];
      end
   end

   always_ff @(posedge clock) begin
      gain_ff <= gain_in;
   end

   // gain is unsigned, so give it a zero sign bit
   assign product = PROD_BITS'(sample) * PROD_BITS'($signed({1'b0, gain_ff}));

   // arithmetic shift right by 31, floor rounding
   assign scaled = product[flrg_pkg::SAMPLE_BITS+30:31];
   assign gain   = gain_ff;

endmodule

>>> tb/floor_line_render_gain_checker.sv
// checker for the floor line renderer: predicts every rendered bin and compares results
`timescale 1ns / 1ps

module floor_line_render_gain_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [flrg_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                               req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [flrg_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                               rsp_tuser,
   output int                                 mismatch_count,
   output int                                 pending_bins
);

   typedef struct {
      logic [flrg_pkg::POS_BITS-1:0]    position;
      logic [flrg_pkg::IDX_BITS-1:0]    floor_index;
      logic [flrg_pkg::GAIN_BITS-1:0]   gain;
      logic [flrg_pkg::SAMPLE_BITS-1:0] scaled;
      logic                             bad_span;
   } gained_bin_type;

   // decimal mantissas of the floor db table; the exponent drops by one wherever the
   // eight-digit mantissa falls below the previous one, seven-digit ones get a zero appended
   localparam int unsigned DB_MANTISSA [256] = '{
      10649863, 11341951, 12079015, 12863978, 13699951, 14590251, 15538408, 16548181,
      17623575, 18768855, 19988561,  2128753, 22670913, 24144197, 25713223, 27384213,
      29163793, 31059021, 33077411, 35226968, 37516214, 39954229, 42550680, 45315863,
      48260743, 51396998, 54737065, 58294187, 62082472, 66116941, 70413592, 74989464,
      79862701, 85052630, 90579828, 96466216, 10273513, 10941144, 11652161, 12409384,
      13215816, 14074654, 14989305, 15963394, 17000785, 18105592, 19282195, 20535261,
      21869758, 23290978, 24804557, 26416497, 28133190, 29961443, 31908506, 33982101,
      36190449, 38542308, 41047004, 43714470, 46555282, 49580707, 52802740, 56234160,
      59888572, 63780469, 67925283, 72339451, 77040476, 82047000, 87378876, 93057248,
      99104632, 10554501, 11240392, 11970856, 12748789, 13577278, 14459606, 15399272,
      16400004, 17465768, 18600792, 19809576, 21096914, 22467911, 23928002, 25482978,
      27139006, 28902651, 30780908, 32781225, 34911534, 37180282, 39596466, 42169667,
      44910090, 47828601, 50936773, 54246931, 57772202, 61526565, 65524908, 69783085,
      74317983, 79147585, 84291040, 89768747, 95602426, 10181521, 10843174, 11547824,
      12298267, 13097477, 13948625, 14855085, 15820453, 16848555, 17943469, 19109536,
      20351382, 21673929, 23082423, 24582449, 26179955, 27881276, 29693158, 31622787,
      33677814, 35866388, 38197188, 40679456, 43323036, 46138411, 49136745, 52329927,
      55730621, 59352311, 63209358, 67317058, 71691700, 76350630, 81312324, 86596457,
      92223983, 98217216, 10459992, 11139742, 11863665, 12634633, 13455702, 14330129,
      15261382, 16253153, 17309374, 18434235, 19632195, 20908006, 22266726, 23713743,
      25254795, 26895994, 28643847, 30505286, 32487691, 34598925, 36847358, 39241906,
      41792066, 44507950, 47400328, 50480668, 53761186, 57254891, 60975636, 64938176,
      69158225, 73652516, 78438871, 83536271, 88964928,  9474637, 10090352, 10746080,
      11444421, 12188144, 12980198, 13823725, 14722068, 15678791, 16697687, 17782797,
      18938423, 20169149, 21479854, 22875735, 24362330, 25945531, 27631618, 29427276,
      31339626, 33376252, 35545228, 37855157, 40315199, 42935108, 45725273, 48696758,
      51861348, 55231591, 58820850, 62643361, 66714279, 71049749, 75666962, 80584227,
      85821044, 91398179, 97337747, 10366330, 11039993, 11757434, 12521498, 13335215,
      14201813, 15124727, 16107617, 17154380, 18269168, 19456402, 20720788, 22067342,
      23501402, 25028656, 26655159, 28387361, 30232132, 32196786, 34289114, 36517414,
      38890521, 41417847, 44109412, 46975890, 50028648, 53279791, 56742212, 60429640,
      64356699, 68538959, 72993007, 77736504, 82788260, 88168307,  9389798,        1
   };

   logic [flrg_pkg::GAIN_BITS-1:0] gain_table [256];

   // line state
   logic [15:0] err_acc;
   logic [15:0] err_inc;
   logic [15:0] run_len;
   logic [15:0] cur_pos;
   logic [15:0] steps_left;
   logic [8:0]  level;
   int          base_step;
   int          round_step;
   logic        span_bad;

   gained_bin_type gained_bins [$];

   initial begin : build_gain_table
      longint unsigned mant;
      longint unsigned prev;
      longint unsigned scale;
      prev  = 0;
      scale = 64'd100000000000000;
      for (int i = 0; i < 255; i++) begin
         mant = DB_MANTISSA[i];
         if (mant < 10000000) mant = mant * 10;
         if (mant < prev) scale = scale / 10;
         prev = mant;
         // q1.31, nearest with halves up
         gain_table[i] = 32'(((mant << 31) + scale / 2) / scale);
      end
      gain_table[255] = 32'h8000_0000;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
   endtask

   function automatic gained_bin_type render_bin(input logic head,
                                                 input logic [flrg_pkg::REQ_DATA_BITS-1:0] item);
      int             run;
      int             dy;
      int             ady;
      int             quot;
      int             prod;
      int             sum;
      longint         product;
      gained_bin_type bin;
      if (head) begin
         run     = int'(item[31:16]) - int'(item[15:0]);
         dy      = int'(item[47:40]) - int'(item[39:32]);
         cur_pos = item[15:0];
         level   = {1'b0, item[39:32]};
         err_acc = '0;
         if (run <= 0) begin
            span_bad   = 1'b1;
            base_step  = 0;
            round_step = 0;
            err_inc    = '0;
            run_len    = '0;
            steps_left = '0;
         end else begin
            ady        = (dy < 0) ? -dy : dy;
            quot       = dy / run;
            prod       = quot * run;
            span_bad   = 1'b0;
            base_step  = quot;
            round_step = (dy < 0) ? quot - 1 : quot + 1;
            err_inc    = 16'(ady - ((prod < 0) ? -prod : prod));
            run_len    = 16'(run);
            steps_left = 16'(run - 1);
         end
      end else begin
         cur_pos = cur_pos + 16'd1;
         if (steps_left != 0) begin
            sum = int'(err_acc) + int'(err_inc);
            if (sum >= int'(run_len)) begin
               sum   = sum - int'(run_len);
               level = 9'(int'(level) + round_step);
            end else begin
               level = 9'(int'(level) + base_step);
            end
            err_acc    = 16'(sum);
            steps_left = steps_left - 16'd1;
         end
      end
      bin.position    = cur_pos;
      bin.floor_index = level[7:0];
      bin.gain        = gain_table[level[7:0]];
      product         = longint'($signed(item[71:48])) * longint'(bin.gain);
      bin.scaled      = 24'(product >>> 31);
      bin.bad_span    = span_bad;
      return bin;
   endfunction

   always @(posedge clock) begin : track_bins
      gained_bin_type want;
      if (reset) begin
         err_acc        = '0;
         err_inc        = '0;
         run_len        = '0;
         cur_pos        = '0;
         steps_left     = '0;
         level          = '0;
         base_step      = 0;
         round_step     = 0;
         span_bad       = 1'b0;
         mismatch_count = 0;
         gained_bins.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (gained_bins.size() == 0) begin
               report_mismatch("unexpected result", 64'(rsp_tdata), '0);
            end else begin
               want = gained_bins.pop_front();
               if (rsp_tdata[15:0] !== want.position)
                  report_mismatch("position", 64'(rsp_tdata[15:0]), 64'(want.position));
               if (rsp_tdata[23:16] !== want.floor_index)
                  report_mismatch("floor_index", 64'(rsp_tdata[23:16]), 64'(want.floor_index));
               if (rsp_tdata[55:24] !== want.gain)
                  report_mismatch("gain", 64'(rsp_tdata[55:24]), 64'(want.gain));
               if (rsp_tdata[79:56] !== want.scaled)
                  report_mismatch("scaled_sample", 64'(rsp_tdata[79:56]), 64'(want.scaled));
               if (rsp_tuser !== want.bad_span)
                  report_mismatch("bad_span", 64'(rsp_tuser), 64'(want.bad_span));
            end
         end
         if (req_tvalid && req_tready) gained_bins.push_back(render_bin(req_tuser, req_tdata));
      end
      pending_bins = gained_bins.size();
   end

endmodule

>>> tb/floor_line_render_gain_tb.sv
// testbench top for the floor line renderer: stimulus, flow control and verdict
`timescale 1ns / 1ps

module floor_line_render_gain_tb;

   localparam int CYCLE_LIMIT  = 400000;  // far above the slowest legal run
   localparam int RANDOM_BINS  = 1300;
   localparam int HOLD_CYCLES  = 200;     // long receiver hold-off, fills the block
   localparam int DRAIN_CYCLES = 30;
   localparam int SENDER       = 0;
   localparam int RECEIVER     = 1;

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   // x_start[15:0], x_end[31:16], y_start[39:32], y_end[47:40], sample[71:48]
   logic [flrg_pkg::REQ_DATA_BITS-1:0] req_tdata  = '0;
   // new_segment[0]
   logic                               req_tuser  = 1'b0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   // position[15:0], floor_index[23:16], gain[55:24], scaled_sample[79:56]
   logic [flrg_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   // bad_span[0]
   logic                               rsp_tuser;

   int mismatch_count;
   int pending_bins;
   int cycle_count  = 0;
   int sent_bins    = 0;
   bit hold_request = 1'b0;
   // per side: when set, that side runs without idle cycles for a stretch
   bit eager [2]    = '{1'b0, 1'b0};

   floor_line_render_gain u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   floor_line_render_gain_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending_bins   (pending_bins)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // random idle gap before the next transaction; now and then a side
   // switches into or out of a stretch with no idling at all
   function automatic int draw_wait(input int side);
      if ($urandom_range(0, 19) == 0) eager[side] = !eager[side];
      return eager[side] ? 0 : $urandom_range(0, 10);
   endfunction

   // mostly random samples, with the extremes and values around zero mixed in
   function automatic logic [23:0] draw_sample();
      case ($urandom_range(0, 7))
         0:       return 24'h7F_FFFF;
         1:       return 24'h80_0000;
         2:       return 24'($urandom_range(0, 15)) - 24'd8;
         default: return 24'($urandom);
      endcase
   endfunction

   // floor level endpoints, biased toward the table ends
   function automatic logic [7:0] draw_level();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // one request transaction; entered and left at a falling edge
   task automatic send_bin(input logic head, input logic [15:0] xs, input logic [15:0] xe,
                           input logic [7:0] ys, input logic [7:0] ye,
                           input logic [23:0] sample);
      int gap;
      gap = draw_wait(SENDER);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= head;
      req_tdata  <= {sample, ye, ys, xe, xs};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent_bins++;
   endtask

   // segment head followed by samples; endpoint fields of the followers are junk
   task automatic send_segment(input logic [15:0] xs, input logic [15:0] xe,
                               input logic [7:0] ys, input logic [7:0] ye, input int follow);
      send_bin(1'b1, xs, xe, ys, ye, draw_sample());
      repeat (follow)
         send_bin(1'b0, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                  draw_sample());
   endtask

   // take the request side quiet until every predicted bin has come back
   task automatic drain_bins();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_bins != 0) @(negedge clock);
   endtask

   // result side: random stalls, plus the long hold-off on request
   initial begin : result_sink
      int stall;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         stall = draw_wait(RECEIVER);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin : stimulus
      int          kind;
      int          run;
      int          follow;
      int          target;
      bit          hold_done;
      bit          pause_done;
      logic [15:0] xs;
      hold_done  = 1'b0;
      pause_done = 1'b0;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // no segment loaded yet: level 0, position counts up from 1
      send_bin(1'b0, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 24'h7F_FFFF);
      send_bin(1'b0, 16'h0000, 16'h0000, 8'h00, 8'h00, 24'h80_0000);
      // steep rise over 4 bins, then one sample past the end
      send_bin(1'b1, 16'd0, 16'd4, 8'd0, 8'd255, 24'h00_0000);
      send_bin(1'b0, 16'd0, 16'd0, 8'd0, 8'd0, 24'h7F_FFFF);
      send_bin(1'b0, 16'd0, 16'd0, 8'd0, 8'd0, 24'h80_0000);
      send_bin(1'b0, 16'd0, 16'd0, 8'd0, 8'd0, 24'h00_0001);
      send_bin(1'b0, 16'd0, 16'd0, 8'd0, 8'd0, 24'hFF_FFFF);
      // steep fall, full-scale gain at the head
      send_bin(1'b1, 16'd100, 16'd103, 8'd255, 8'd0, 24'h7F_FFFF);
      send_bin(1'b0, 16'd0, 16'd0, 8'd0, 8'd0, 24'h80_0000);
      send_bin(1'b0, 16'd0, 16'd0, 8'd0, 8'd0, 24'h7F_FFFF);
      send_bin(1'b0, 16'd0, 16'd0, 8'd0, 8'd0, 24'hFF_FFFF);
      // empty span at the top of the range; the follower wraps position to 0
      send_bin(1'b1, 16'hFFFF, 16'hFFFF, 8'd7, 8'd9, 24'h80_0000);
      send_bin(1'b0, 16'd0, 16'd0, 8'd0, 8'd0, 24'h7F_FFFF);
      // reversed span
      send_bin(1'b1, 16'hFFFF, 16'h0000, 8'd200, 8'd3, 24'h7F_FFFF);
      // flat line
      send_bin(1'b1, 16'd10, 16'd13, 8'd128, 8'd128, 24'h12_3456);
      send_bin(1'b0, 16'd0, 16'd0, 8'd0, 8'd0, 24'hED_CBA9);
      send_bin(1'b0, 16'd0, 16'd0, 8'd0, 8'd0, 24'h7F_FFFF);
      // longest run, shallow slope with the error term carrying
      send_bin(1'b1, 16'd0, 16'hFFFF, 8'd0, 8'd255, 24'h7F_FFFF);
      send_bin(1'b0, 16'd0, 16'd0, 8'd0, 8'd0, 24'h80_0000);
      send_bin(1'b0, 16'd0, 16'd0, 8'd0, 8'd0, 24'h55_5555);
      send_bin(1'b0, 16'd0, 16'd0, 8'd0, 8'd0, 24'hAA_AAAA);
      // one-bin run: no steps at all
      send_bin(1'b1, 16'd5, 16'd6, 8'd255, 8'd0, 24'h80_0000);
      send_bin(1'b0, 16'd0, 16'd0, 8'd0, 8'd0, 24'h7F_FFFF);

      target = sent_bins + RANDOM_BINS;
      while (sent_bins < target) begin
         // long result hold-off while requests keep coming back to back
         if (!hold_done && sent_bins >= target - RANDOM_BINS + 300) begin
            hold_done      = 1'b1;
            hold_request   = 1'b1;
            eager[SENDER]  = 1'b1;
         end
         // quiet the request side until the block has emptied
         if (!pause_done && sent_bins >= target - RANDOM_BINS + 800) begin
            pause_done = 1'b1;
            drain_bins();
         end
         kind = $urandom_range(0, 99);
         if (kind < 8) begin
            // stray sample with random endpoint fields
            send_bin(1'b0, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                     draw_sample());
         end else if (kind < 18) begin
            // empty or reversed span
            xs = 16'($urandom);
            send_segment(xs, 16'($urandom_range(0, xs)), draw_level(), draw_level(),
                         $urandom_range(0, 3));
         end else begin
            // well-formed segment, mostly short runs, sometimes overrun by a few samples
            run    = (kind < 24) ? $urandom_range(49, 65535) : $urandom_range(1, 48);
            xs     = 16'($urandom_range(0, 65535 - run));
            follow = $urandom_range(0, (run > 60) ? 60 : run + 2);
            send_segment(xs, xs + 16'(run), draw_level(), draw_level(), follow);
         end
      end

      drain_bins();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/flrg_pkg.sv
rtl/core/flrg_divider.sv
rtl/core/flrg_scale.sv
rtl/core/floor_line_render_gain.sv
tb/floor_line_render_gain_checker.sv
tb/floor_line_render_gain_tb.sv
